// ===== rtl/hgc_pkg.sv =====
// Shared types, constants and codes for the height grid colorizer.
`timescale 1ns / 1ps

package hgc_pkg;

   // Field widths
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned HEIGHT_W = 16;
   localparam int unsigned MASK_W   = 16;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned SIDE_W   = 13;
   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned SUM_W    = HEIGHT_W + 1;
   localparam int unsigned COUNT_W  = 25;
   localparam int unsigned AREA_W   = 2 * SIDE_W;

   // Shared divider: quotient never exceeds 154, so eight quotient bits suffice
   localparam int unsigned QUOT_W   = 8;
   localparam int unsigned NUMER_W  = CHAN_W + SUM_W;
   localparam int unsigned STEP_W   = $clog2(QUOT_W);

   localparam int unsigned MAX_SIDE_DEFAULT = 4097;

   localparam logic [WORD_W-1:0]   HDR_MAGIC   = 32'h5041_4D48;
   localparam logic [WORD_W-1:0]   HDR_VERSION = 32'd101;
   localparam logic [MASK_W-1:0]   TINT_BITS   = 16'h9000;
   localparam logic [COUNT_W-1:0]  COUNT_MAX   = {COUNT_W{1'b1}};

   // Gradient end points and tint amounts
   localparam logic [CHAN_W-1:0] RED_LO   = 8'd40;
   localparam logic [CHAN_W-1:0] RED_HI   = 8'd194;
   localparam logic [CHAN_W-1:0] GREEN_LO = 8'd77;
   localparam logic [CHAN_W-1:0] GREEN_HI = 8'd181;
   localparam logic [CHAN_W-1:0] BLUE_LO  = 8'd58;
   localparam logic [CHAN_W-1:0] BLUE_HI  = 8'd139;
   localparam logic [CHAN_W-1:0] TINT_UP   = 8'd28;
   localparam logic [CHAN_W-1:0] TINT_DOWN = 8'd18;

   // Item kinds
   localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SCAN   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RENDER = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_HEADER = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_DIM_MISS   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_COUNT_MISS = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_ORDER      = 3'd4;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = SIDE_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIMS_KNOWN = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXP_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXP_HEIGHT = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [WORD_W-1:0]   magic_word;
      logic [WORD_W-1:0]   format_version;
      logic [WORD_W-1:0]   grid_cols;
      logic [WORD_W-1:0]   grid_rows;
      logic [HEIGHT_W-1:0] height_a;
      logic [HEIGHT_W-1:0] height_b;
      logic [MASK_W-1:0]   cell_mask;
      logic                last_cell;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                pixel_valid;
      logic [SIDE_W-1:0]   column;
      logic [SIDE_W-1:0]   image_row;
      logic [CHAN_W-1:0]   red;
      logic [CHAN_W-1:0]   green;
      logic [CHAN_W-1:0]   blue;
      logic                frame_end;
   } rsp_type;

   typedef struct packed {
      logic               start;
      logic [NUMER_W-1:0] numer;
      logic [SUM_W-1:0]   denom;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } div_rsp_type;

endpackage

// ===== rtl/height_grid_colorizer.sv =====
// Top level of the height grid colorizer: sequencer, grid state and result register.
`timescale 1ns / 1ps

// Takes one beat at a time on req_ and returns exactly one result beat on rsp_ for
// each. A header beat checks magic word, version and dimensions (2..MAX_SIDE, and
// the expected size when dims_known is set), then a scan pass of every cell builds
// the minimum and maximum of height_a + height_b and checks the cell count on the
// cell marked last. A render pass of the same cells then returns one pixel per cell
// on a green-to-sand gradient, tinted where cell_mask has 0x9000 bits set, with rows
// flipped and frame_end on the final pixel; the position wraps so the image can be
// rendered again. In a render beat the three colour channels go one after another
// through a single restoring divider at one quotient bit per cycle, each channel
// with its own load and hand-off. req_ready is high whenever the sequencer is idle,
// even while a finished result still waits on rsp_; the sequencer then holds its
// result until the output register frees. Configuration writes on csr_ take effect
// at once and must only be made while the block is idle.
module height_grid_colorizer #(
   parameter int unsigned MAX_SIDE = hgc_pkg::MAX_SIDE_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  hgc_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output hgc_pkg::rsp_type                   rsp_data,
   input  logic                               csr_write_en,
   input  logic [hgc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [hgc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import hgc_pkg::*;

   // Sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EXEC   = 2'd1;
   localparam logic [1:0] ST_DIV    = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   // Channel order through the divider
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   logic [1:0]          state_ff, state_in;

   // Configuration
   logic                dims_known_ff, dims_known_in;
   logic [SIDE_W-1:0]   exp_width_ff, exp_width_in;
   logic [SIDE_W-1:0]   exp_height_ff, exp_height_in;

   // Grid state
   logic [SIDE_W-1:0]   cols_held_ff, cols_held_in;
   logic [SIDE_W-1:0]   rows_held_ff, rows_held_in;
   logic                header_good_ff, header_good_in;
   logic [SUM_W-1:0]    low_sum_ff, low_sum_in;
   logic [SUM_W-1:0]    high_sum_ff, high_sum_in;
   logic [COUNT_W-1:0]  scan_count_ff, scan_count_in;
   logic                scan_good_ff, scan_good_in;
   logic [SIDE_W-1:0]   x_pos_ff, x_pos_in;
   logic [SIDE_W-1:0]   y_pos_ff, y_pos_in;

   // Item held while it is worked on
   req_type             req_ff, req_in;
   logic [SUM_W-1:0]    d_ff, d_in;
   logic [SUM_W-1:0]    span_ff, span_in;
   logic [1:0]          chan_ff, chan_in;
   logic                div_run_ff, div_run_in;
   logic [QUOT_W-1:0]   q_red_ff, q_red_in;
   logic [QUOT_W-1:0]   q_green_ff, q_green_in;
   logic [QUOT_W-1:0]   q_blue_ff, q_blue_in;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   div_req_type         div_req;
   div_rsp_type         div_rsp;

   // Working values
   logic                slot_free;
   logic [SUM_W-1:0]    cell_sum;
   logic [SUM_W-1:0]    span_calc;
   logic [SUM_W-1:0]    d_calc;
   logic [COUNT_W-1:0]  count_next;
   logic [AREA_W-1:0]   grid_area;
   logic                header_bad;
   logic                dims_miss;
   logic [CHAN_W-1:0]   coef;
   logic [CHAN_W:0]     red_ramp, red_tint;
   logic [CHAN_W-1:0]   green_ramp, blue_ramp;
   logic [CHAN_W-1:0]   red_pix, green_pix, blue_pix;
   logic                tint;
   logic                x_last, y_last, frame_last;
   rsp_type             beat;

   hgc_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Header checks
   assign header_bad = (req_ff.magic_word != HDR_MAGIC) ||
                       (req_ff.format_version != HDR_VERSION) ||
                       (req_ff.grid_cols < WORD_W'(2)) || (req_ff.grid_rows < WORD_W'(2)) ||
                       (req_ff.grid_cols > WORD_W'(MAX_SIDE)) ||
                       (req_ff.grid_rows > WORD_W'(MAX_SIDE));
   assign dims_miss  = dims_known_ff &&
                       ((req_ff.grid_cols != WORD_W'(exp_width_ff)) ||
                        (req_ff.grid_rows != WORD_W'(exp_height_ff)));

   // Scan statistics
   assign cell_sum   = SUM_W'(req_ff.height_a) + SUM_W'(req_ff.height_b);
   assign count_next = (scan_count_ff == COUNT_MAX) ? scan_count_ff
                                                    : scan_count_ff + COUNT_W'(1);
   assign grid_area  = AREA_W'(cols_held_ff) * AREA_W'(rows_held_ff);

   // Render offset: span at least 1, offset clamped into 0..span
   always_comb begin
      span_calc = (high_sum_ff > low_sum_ff) ? high_sum_ff - low_sum_ff : SUM_W'(1);
      d_calc    = (cell_sum > low_sum_ff) ? cell_sum - low_sum_ff : '0;
      if (d_calc > span_calc) begin
         d_calc = span_calc;
      end
   end

   // Gradient step for the channel now in the divider
   always_comb begin
      case (chan_ff)
         CH_RED:   coef = RED_HI - RED_LO;
         CH_GREEN: coef = GREEN_HI - GREEN_LO;
         default:  coef = BLUE_HI - BLUE_LO;
      endcase
   end

   // Pixel colour and position
   assign tint       = (req_ff.cell_mask & TINT_BITS) != '0;
   assign red_ramp   = (CHAN_W+1)'(RED_LO) + (CHAN_W+1)'(q_red_ff);
   assign green_ramp = GREEN_LO + CHAN_W'(q_green_ff);
   assign blue_ramp  = BLUE_LO + CHAN_W'(q_blue_ff);
   assign red_tint   = red_ramp + (CHAN_W+1)'(TINT_UP);
   assign red_pix    = !tint ? red_ramp[CHAN_W-1:0]
                     : (red_tint[CHAN_W] ? {CHAN_W{1'b1}} : red_tint[CHAN_W-1:0]);
   assign green_pix  = !tint ? green_ramp
                     : ((green_ramp > TINT_DOWN) ? green_ramp - TINT_DOWN : '0);
   assign blue_pix   = !tint ? blue_ramp
                     : ((blue_ramp > TINT_DOWN) ? blue_ramp - TINT_DOWN : '0);
   assign x_last     = ((SIDE_W+1)'(x_pos_ff) + (SIDE_W+1)'(1)) >= (SIDE_W+1)'(cols_held_ff);
   assign y_last     = ((SIDE_W+1)'(y_pos_ff) + (SIDE_W+1)'(1)) >= (SIDE_W+1)'(rows_held_ff);
   assign frame_last = x_last && y_last;

   always_comb begin
      state_in       = state_ff;
      dims_known_in  = dims_known_ff;
      exp_width_in   = exp_width_ff;
      exp_height_in  = exp_height_ff;
      cols_held_in   = cols_held_ff;
      rows_held_in   = rows_held_ff;
      header_good_in = header_good_ff;
      low_sum_in     = low_sum_ff;
      high_sum_in    = high_sum_ff;
      scan_count_in  = scan_count_ff;
      scan_good_in   = scan_good_ff;
      x_pos_in       = x_pos_ff;
      y_pos_in       = y_pos_ff;
      req_in         = req_ff;
      d_in           = d_ff;
      span_in        = span_ff;
      chan_in        = chan_ff;
      div_run_in     = div_run_ff;
      q_red_in       = q_red_ff;
      q_green_in     = q_green_ff;
      q_blue_in      = q_blue_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      beat           = '0;

      div_req.start  = 1'b0;
      div_req.numer  = NUMER_W'(coef) * NUMER_W'(d_ff);
      div_req.denom  = span_ff;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_DIMS_KNOWN: dims_known_in = csr_wdata[0];
            CSR_EXP_WIDTH:  exp_width_in  = csr_wdata;
            CSR_EXP_HEIGHT: exp_height_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            unique case (req_ff.kind)
               KIND_HEADER: begin
                  if (slot_free) begin
                     // every header restarts the scan
                     low_sum_in    = {SUM_W{1'b1}};
                     high_sum_in   = '0;
                     scan_count_in = '0;
                     scan_good_in  = 1'b0;
                     x_pos_in      = '0;
                     y_pos_in      = '0;
                     if (header_bad) begin
                        beat.status    = STATUS_BAD_HEADER;
                        header_good_in = 1'b0;
                     end else if (dims_miss) begin
                        beat.status    = STATUS_DIM_MISS;
                        header_good_in = 1'b0;
                     end else begin
                        cols_held_in   = req_ff.grid_cols[SIDE_W-1:0];
                        rows_held_in   = req_ff.grid_rows[SIDE_W-1:0];
                        header_good_in = 1'b1;
                     end
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = beat;
                     state_in     = ST_IDLE;
                  end
               end

               KIND_SCAN: begin
                  if (slot_free) begin
                     if (!header_good_ff || scan_good_ff) begin
                        beat.status = STATUS_ORDER;
                     end else begin
                        if (cell_sum < low_sum_ff) begin
                           low_sum_in = cell_sum;
                        end
                        if (cell_sum > high_sum_ff) begin
                           high_sum_in = cell_sum;
                        end
                        scan_count_in = count_next;
                        if (req_ff.last_cell) begin
                           if (AREA_W'(count_next) == grid_area) begin
                              scan_good_in = 1'b1;
                              x_pos_in     = '0;
                              y_pos_in     = '0;
                           end else begin
                              beat.status    = STATUS_COUNT_MISS;
                              header_good_in = 1'b0;
                           end
                        end
                     end
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = beat;
                     state_in     = ST_IDLE;
                  end
               end

               KIND_RENDER: begin
                  if (!header_good_ff || !scan_good_ff) begin
                     if (slot_free) begin
                        beat.status  = STATUS_ORDER;
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = beat;
                        state_in     = ST_IDLE;
                     end
                  end else begin
                     d_in       = d_calc;
                     span_in    = span_calc;
                     chan_in    = CH_RED;
                     div_run_in = 1'b0;
                     state_in   = ST_DIV;
                  end
               end

               default: begin
                  if (slot_free) begin
                     beat.status  = STATUS_ORDER;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = beat;
                     state_in     = ST_IDLE;
                  end
               end
            endcase
         end

         ST_DIV: begin
            if (!div_run_ff) begin
               div_req.start = 1'b1;
               div_run_in    = 1'b1;
            end else if (div_rsp.done) begin
               div_run_in = 1'b0;
               case (chan_ff)
                  CH_RED:   q_red_in   = div_rsp.quot;
                  CH_GREEN: q_green_in = div_rsp.quot;
                  default:  q_blue_in  = div_rsp.quot;
               endcase
               if (chan_ff == CH_BLUE) begin
                  state_in = ST_FINISH;
               end else begin
                  chan_in = chan_ff + 2'd1;
               end
            end
         end

         ST_FINISH: begin
            if (slot_free) begin
               beat.status      = STATUS_OK;
               beat.pixel_valid = 1'b1;
               beat.column      = x_pos_ff;
               beat.image_row   = rows_held_ff - SIDE_W'(1) - y_pos_ff;
               beat.red         = red_pix;
               beat.green       = green_pix;
               beat.blue        = blue_pix;
               beat.frame_end   = frame_last;
               // raster advance, wrapping to the origin after the last pixel
               if (frame_last) begin
                  x_pos_in = '0;
                  y_pos_in = '0;
               end else if (x_last) begin
                  x_pos_in = '0;
                  y_pos_in = y_pos_ff + SIDE_W'(1);
               end else begin
                  x_pos_in = x_pos_ff + SIDE_W'(1);
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = beat;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         dims_known_ff  <= 1'b0;
         exp_width_ff   <= '0;
         exp_height_ff  <= '0;
         cols_held_ff   <= '0;
         rows_held_ff   <= '0;
         header_good_ff <= 1'b0;
         low_sum_ff     <= {SUM_W{1'b1}};
         high_sum_ff    <= '0;
         scan_count_ff  <= '0;
         scan_good_ff   <= 1'b0;
         x_pos_ff       <= '0;
         y_pos_ff       <= '0;
         chan_ff        <= CH_RED;
         div_run_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         dims_known_ff  <= dims_known_in;
         exp_width_ff   <= exp_width_in;
         exp_height_ff  <= exp_height_in;
         cols_held_ff   <= cols_held_in;
         rows_held_ff   <= rows_held_in;
         header_good_ff <= header_good_in;
         low_sum_ff     <= low_sum_in;
         high_sum_ff    <= high_sum_in;
         scan_count_ff  <= scan_count_in;
         scan_good_ff   <= scan_good_in;
         x_pos_ff       <= x_pos_in;
         y_pos_ff       <= y_pos_in;
         chan_ff        <= chan_in;
         div_run_ff     <= div_run_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload, no reset needed
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      d_ff        <= d_in;
      span_ff     <= span_in;
      q_red_ff    <= q_red_in;
      q_green_ff  <= q_green_in;
      q_blue_ff   <= q_blue_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== rtl/hgc_divider.sv =====
// Restoring divider, one quotient bit per cycle, shared by the three colour channels.
`timescale 1ns / 1ps

module hgc_divider (
   input  logic                clock,
   input  logic                reset,
   input  hgc_pkg::div_req_type div_req,
   output hgc_pkg::div_rsp_type div_rsp
);
   import hgc_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [NUMER_W-1:0]  rem_ff, rem_in;
   logic [NUMER_W-1:0]  dvs_ff, dvs_in;
   logic [QUOT_W-1:0]   quot_ff, quot_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      if (div_req.start) begin
         rem_in  = div_req.numer;
         // divisor aligned to the top quotient bit
         dvs_in  = NUMER_W'({div_req.denom, {(QUOT_W-1){1'b0}}});
         quot_in = '0;
         step_in = STEP_W'(QUOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= dvs_ff) begin
            rem_in  = rem_ff - dvs_ff;
            quot_in = {quot_ff[QUOT_W-2:0], 1'b1};
         end else begin
            quot_in = {quot_ff[QUOT_W-2:0], 1'b0};
         end
         dvs_in = dvs_ff >> 1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

// ===== tb/height_grid_colorizer_checker.sv =====
// Scoreboard for the height grid colorizer: predicts every result beat and checks it.
`timescale 1ns / 1ps

module height_grid_colorizer_checker #(
   parameter int unsigned MAX_SIDE = hgc_pkg::MAX_SIDE_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  hgc_pkg::req_type                 req_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  hgc_pkg::rsp_type                 rsp_data,
   input  logic                             csr_write_en,
   input  logic [hgc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [hgc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                               fail_count,
   output int                               pending_count,
   output int                               pixel_count,
   output int                               frame_count,
   output int                               status_count
);
   import hgc_pkg::*;

   // register copies
   logic                dims_known_q;
   logic [SIDE_W-1:0]   exp_width_q;
   logic [SIDE_W-1:0]   exp_height_q;

   // grid state
   logic [SIDE_W-1:0]   cols_q;
   logic [SIDE_W-1:0]   rows_q;
   logic                grid_ok;
   logic [SUM_W-1:0]    sum_low;
   logic [SUM_W-1:0]    sum_high;
   logic [COUNT_W-1:0]  cells_seen;
   logic                scan_ok;
   logic [SIDE_W-1:0]   px_x;
   logic [SIDE_W-1:0]   px_y;

   rsp_type             due_results[$];
   int unsigned         results_seen;

   function automatic void restart_scan();
      sum_low    = '1;
      sum_high   = '0;
      cells_seen = '0;
      scan_ok    = 1'b0;
      px_x       = '0;
      px_y       = '0;
   endfunction

   function automatic int unsigned blend(input int unsigned lo, input int unsigned hi,
                                         input int unsigned delta, input int unsigned span);
      return lo + ((hi - lo) * delta) / span;
   endfunction

   function automatic rsp_type colour_cell(input req_type beat);
      rsp_type           res;
      logic [SUM_W-1:0]  cell_sum;
      logic [SUM_W-1:0]  span;
      logic [SUM_W-1:0]  delta;
      int unsigned       area;
      int unsigned       red_v;
      int unsigned       green_v;
      int unsigned       blue_v;
      logic              at_end;
      res      = '0;
      cell_sum = {1'b0, beat.height_a} + {1'b0, beat.height_b};
      case (beat.kind)
         KIND_HEADER: begin
            restart_scan();
            if (beat.magic_word != HDR_MAGIC || beat.format_version != HDR_VERSION ||
                beat.grid_cols < 32'd2 || beat.grid_rows < 32'd2 ||
                beat.grid_cols > 32'(MAX_SIDE) || beat.grid_rows > 32'(MAX_SIDE)) begin
               res.status = STATUS_BAD_HEADER;
               grid_ok    = 1'b0;
            end else if (dims_known_q && (beat.grid_cols != 32'(exp_width_q) ||
                                          beat.grid_rows != 32'(exp_height_q))) begin
               res.status = STATUS_DIM_MISS;
               grid_ok    = 1'b0;
            end else begin
               cols_q  = beat.grid_cols[SIDE_W-1:0];
               rows_q  = beat.grid_rows[SIDE_W-1:0];
               grid_ok = 1'b1;
            end
         end
         KIND_SCAN: begin
            if (!grid_ok || scan_ok) begin
               res.status = STATUS_ORDER;
            end else begin
               if (cell_sum < sum_low) sum_low = cell_sum;
               if (cell_sum > sum_high) sum_high = cell_sum;
               if (cells_seen != COUNT_MAX) cells_seen = cells_seen + COUNT_W'(1);
               if (beat.last_cell) begin
                  area = 32'(cols_q) * 32'(rows_q);
                  if (32'(cells_seen) == area) begin
                     scan_ok = 1'b1;
                     px_x    = '0;
                     px_y    = '0;
                  end else begin
                     res.status = STATUS_COUNT_MISS;
                     grid_ok    = 1'b0;
                  end
               end
            end
         end
         KIND_RENDER: begin
            if (!grid_ok || !scan_ok) begin
               res.status = STATUS_ORDER;
            end else begin
               span  = (sum_high > sum_low) ? sum_high - sum_low : SUM_W'(1);
               delta = (cell_sum > sum_low) ? cell_sum - sum_low : '0;
               if (delta > span) delta = span;
               red_v   = blend(32'(RED_LO), 32'(RED_HI), 32'(delta), 32'(span));
               green_v = blend(32'(GREEN_LO), 32'(GREEN_HI), 32'(delta), 32'(span));
               blue_v  = blend(32'(BLUE_LO), 32'(BLUE_HI), 32'(delta), 32'(span));
               if ((beat.cell_mask & TINT_BITS) != '0) begin
                  red_v   = (red_v + 32'(TINT_UP) > 32'd255) ? 32'd255
                                                             : red_v + 32'(TINT_UP);
                  green_v = (green_v > 32'(TINT_DOWN)) ? green_v - 32'(TINT_DOWN) : 32'd0;
                  blue_v  = (blue_v > 32'(TINT_DOWN)) ? blue_v - 32'(TINT_DOWN) : 32'd0;
               end
               at_end = ((SIDE_W+1)'(px_x) + (SIDE_W+1)'(1) >= (SIDE_W+1)'(cols_q)) &&
                        ((SIDE_W+1)'(px_y) + (SIDE_W+1)'(1) >= (SIDE_W+1)'(rows_q));
               res.pixel_valid = 1'b1;
               res.column      = px_x;
               res.image_row   = rows_q - SIDE_W'(1) - px_y;
               res.red         = red_v[CHAN_W-1:0];
               res.green       = green_v[CHAN_W-1:0];
               res.blue        = blue_v[CHAN_W-1:0];
               res.frame_end   = at_end;
               if (at_end) begin
                  px_x = '0;
                  px_y = '0;
               end else if ((SIDE_W+1)'(px_x) + (SIDE_W+1)'(1) >= (SIDE_W+1)'(cols_q)) begin
                  px_x = '0;
                  px_y = px_y + SIDE_W'(1);
               end else begin
                  px_x = px_x + SIDE_W'(1);
               end
            end
         end
         default: res.status = STATUS_ORDER;
      endcase
      return res;
   endfunction

   task automatic check_result(input rsp_type want, input rsp_type got);
      string diffs;
      diffs = "";
      if (got.status !== want.status) diffs = {diffs, " status"};
      if (got.pixel_valid !== want.pixel_valid) diffs = {diffs, " pixel_valid"};
      if (got.column !== want.column) diffs = {diffs, " column"};
      if (got.image_row !== want.image_row) diffs = {diffs, " image_row"};
      if (got.red !== want.red) diffs = {diffs, " red"};
      if (got.green !== want.green) diffs = {diffs, " green"};
      if (got.blue !== want.blue) diffs = {diffs, " blue"};
      if (got.frame_end !== want.frame_end) diffs = {diffs, " frame_end"};
      if (want.pixel_valid) pixel_count++;
      else status_count++;
      if (want.frame_end) frame_count++;
      if (diffs != "") begin
         fail_count++;
         if (fail_count <= 10)
            $display("result %0d wrong in%s: want st=%0d pix=%0d x=%0d y=%0d rgb=%0d/%0d/%0d end=%0d",
                     results_seen, diffs, want.status, want.pixel_valid, want.column,
                     want.image_row, want.red, want.green, want.blue, want.frame_end);
         if (fail_count <= 10)
            $display("   got st=%0d pix=%0d x=%0d y=%0d rgb=%0d/%0d/%0d end=%0d",
                     got.status, got.pixel_valid, got.column, got.image_row,
                     got.red, got.green, got.blue, got.frame_end);
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         dims_known_q = 1'b0;
         exp_width_q  = '0;
         exp_height_q = '0;
         cols_q       = '0;
         rows_q       = '0;
         grid_ok      = 1'b0;
         restart_scan();
         due_results.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_DIMS_KNOWN: dims_known_q = csr_wdata[0];
               CSR_EXP_WIDTH:  exp_width_q  = csr_wdata;
               CSR_EXP_HEIGHT: exp_height_q = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            want = colour_cell(req_data);
            due_results.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (due_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("result %0d arrived with nothing outstanding", results_seen);
            end else begin
               want = due_results.pop_front();
               check_result(want, rsp_data);
            end
         end
      end
      pending_count = due_results.size();
   end

endmodule

// ===== tb/height_grid_colorizer_tb.sv =====
// Testbench top for the height grid colorizer: stimulus, pacing, watchdog and verdict.
`timescale 1ns / 1ps

module height_grid_colorizer_tb;
   import hgc_pkg::*;

   // no accepted beat on either channel for this long means the block has hung
   localparam int unsigned STALL_LIMIT  = 2000;
   // extra wait after draining, so a render beat has room to misbehave
   localparam int unsigned DRAIN_CYCLES = 40;
   // grids with more cells than this only get a short, deliberately wrong scan
   localparam int unsigned GRID_CELLS_MAX = 64;
   localparam int unsigned CELL_IDX_W = $clog2(GRID_CELLS_MAX);
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   req_type                 req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = CSR_DIMS_KNOWN;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // pacing: percentage of cycles each side holds back
   int unsigned             send_gap_pct = 12;
   int unsigned             recv_stall_pct = 86;
   int unsigned             beats_sent = 0;
   int unsigned             stall_cycles = 0;

   // stimulus-side copy of the registers, only used to shape grids
   logic                    dims_known_set = 1'b0;
   logic [SIDE_W-1:0]       exp_w_set = '0;
   logic [SIDE_W-1:0]       exp_h_set = '0;

   // heights of the current grid's scan pass, replayed by the render pass
   logic [HEIGHT_W-1:0]     scan_a [0:GRID_CELLS_MAX-1];
   logic [HEIGHT_W-1:0]     scan_b [0:GRID_CELLS_MAX-1];

   int                      fail_count;
   int                      pending_count;
   int                      pixel_count;
   int                      frame_count;
   int                      status_count;

   always #6 clock = ~clock;

   height_grid_colorizer uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   height_grid_colorizer_checker result_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .pixel_count   (pixel_count),
      .frame_count   (frame_count),
      .status_count  (status_count)
   );

   // Receiver back-pressure, redrawn every cycle.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: counts cycles in which no beat moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Every field random, kind included; callers override what matters.
   function automatic req_type random_beat();
      req_type      beat;
      logic [31:0]  r;
      r = $urandom;
      beat.kind           = r[KIND_W-1:0];
      beat.magic_word     = $urandom;
      beat.format_version = $urandom;
      beat.grid_cols      = $urandom;
      beat.grid_rows      = $urandom;
      r = $urandom;
      beat.height_a       = r[HEIGHT_W-1:0];
      beat.height_b       = r[31:HEIGHT_W];
      r = $urandom;
      beat.cell_mask      = r[MASK_W-1:0];
      beat.last_cell      = r[MASK_W];
      return beat;
   endfunction

   // Roughly three cells in eight carry a tint bit.
   function automatic logic [MASK_W-1:0] pick_mask();
      logic [31:0] r;
      r = $urandom;
      return r[31] ? (r[MASK_W-1:0] & ~TINT_BITS) : r[MASK_W-1:0];
   endfunction

   // Dimensions around the legal bounds, or anything at all.
   function automatic logic [31:0] edge_dim();
      case ($urandom_range(0, 6))
         0: return 32'd0;
         1: return 32'd1;
         2: return 32'd2;
         3: return 32'd4096;
         4: return MAX_SIDE_DEFAULT;
         5: return MAX_SIDE_DEFAULT + 1;
         default: return $urandom;
      endcase
   endfunction

   // Presents one beat from a falling edge and returns at the falling edge after
   // it is taken. Valid is left high so a following beat goes out back to back;
   // it only drops when a gap is drawn or the caller lowers it.
   task automatic send_beat(input req_type beat);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      beats_sent++;
   endtask

   task automatic send_header(input logic [31:0] magic, input logic [31:0] version,
                              input logic [31:0] cols, input logic [31:0] rows);
      req_type beat;
      beat = random_beat();
      beat.kind           = KIND_HEADER;
      beat.magic_word     = magic;
      beat.format_version = version;
      beat.grid_cols      = cols;
      beat.grid_rows      = rows;
      send_beat(beat);
   endtask

   task automatic send_cell(input logic [KIND_W-1:0] kind, input logic [HEIGHT_W-1:0] a,
                            input logic [HEIGHT_W-1:0] b, input logic [MASK_W-1:0] mask,
                            input logic last);
      req_type beat;
      beat = random_beat();
      beat.kind      = kind;
      beat.height_a  = a;
      beat.height_b  = b;
      beat.cell_mask = mask;
      beat.last_cell = last;
      send_beat(beat);
   endtask

   // A misplaced beat that never changes the grid state.
   task automatic send_stray(input logic [KIND_W-1:0] kind);
      req_type     beat;
      logic [31:0] r;
      r = $urandom;
      beat = random_beat();
      beat.kind = r[0] ? kind : KIND_UNUSED;
      send_beat(beat);
   endtask

   // Junk between grids: random beats and near-miss headers.
   task automatic send_noise();
      req_type     beat;
      logic [31:0] r;
      beat = random_beat();
      r = $urandom;
      case ($urandom_range(0, 2))
         0: ;
         1: begin
            beat.kind           = KIND_HEADER;
            beat.magic_word     = HDR_MAGIC;
            beat.format_version = HDR_VERSION;
            beat.grid_cols      = edge_dim();
            beat.grid_rows      = edge_dim();
         end
         default: begin
            // one flipped bit in either the magic word or the version
            beat.kind           = KIND_HEADER;
            beat.magic_word     = r[0] ? HDR_MAGIC ^ (32'h1 << r[5:1]) : HDR_MAGIC;
            beat.format_version = r[0] ? HDR_VERSION : HDR_VERSION ^ (32'h1 << r[5:1]);
            beat.grid_cols      = $urandom_range(2, 7);
            beat.grid_rows      = $urandom_range(2, 7);
         end
      endcase
      send_beat(beat);
   endtask

   // One grid: header, scan pass, render pass. Mostly well formed, with some
   // broken scans, stray beats and repeated renders mixed in.
   task automatic run_grid_session();
      int unsigned          cols;
      int unsigned          rows;
      int unsigned          cells;
      int unsigned          n_scan;
      int unsigned          n_render;
      int unsigned          profile;
      int unsigned          i;
      int unsigned          j;
      logic                 header_passes;
      logic                 broken;
      logic [31:0]          r;
      logic [HEIGHT_W-1:0]  base16;
      logic [HEIGHT_W-1:0]  a;
      logic [HEIGHT_W-1:0]  b;

      if (dims_known_set && $urandom_range(99) < 80) begin
         cols = 32'(exp_w_set);
         rows = 32'(exp_h_set);
      end else if ($urandom_range(99) < 4) begin
         cols = $urandom_range(1) ? MAX_SIDE_DEFAULT : $urandom_range(2, 7);
         rows = (cols == MAX_SIDE_DEFAULT) ? $urandom_range(2, MAX_SIDE_DEFAULT)
                                           : MAX_SIDE_DEFAULT;
      end else begin
         cols = $urandom_range(2, 7);
         rows = $urandom_range(2, 7);
      end
      send_header(HDR_MAGIC, HDR_VERSION, cols, rows);

      header_passes = cols >= 2 && rows >= 2 && cols <= MAX_SIDE_DEFAULT &&
                      rows <= MAX_SIDE_DEFAULT &&
                      (!dims_known_set || (cols == exp_w_set && rows == exp_h_set));
      if (!header_passes) begin
         // the block should turn these away as out of order
         repeat ($urandom_range(0, 2)) begin
            r = $urandom;
            send_cell(KIND_SCAN, r[15:0], r[31:16], pick_mask(), r[0]);
         end
         return;
      end

      cells = cols * rows;
      if (cells > GRID_CELLS_MAX) begin
         // far too many cells to scan: cut it short so the count check trips
         n_scan = $urandom_range(1, 5);
         for (i = 0; i < n_scan; i++) begin
            r = $urandom;
            send_cell(KIND_SCAN, r[15:0], r[31:16], pick_mask(), i == n_scan - 1);
         end
         if ($urandom_range(1)) send_stray(KIND_RENDER);
         return;
      end

      profile = $urandom_range(0, 3);
      r       = $urandom;
      base16  = r[15:0];
      broken  = $urandom_range(99) < 12;
      n_scan  = cells;
      if (broken)
         n_scan = $urandom_range(1) ? $urandom_range(1, cells - 1)
                                    : cells + $urandom_range(1, 3);

      for (i = 0; i < n_scan; i++) begin
         if ($urandom_range(99) < 3) send_stray(KIND_RENDER);
         r = $urandom;
         case (profile)
            0: begin
               a = r[15:0];
               b = r[31:16];
            end
            1: begin
               // narrow band around one level
               a = base16 + r[3:0];
               b = {14'd0, r[5:4]};
            end
            2: begin
               // flat grid: min equals max
               a = base16;
               b = '0;
            end
            default: begin
               a = {HEIGHT_W{r[0]}};
               b = {HEIGHT_W{r[1]}};
            end
         endcase
         scan_a[i[CELL_IDX_W-1:0]] = a;
         scan_b[i[CELL_IDX_W-1:0]] = b;
         send_cell(KIND_SCAN, a, b, pick_mask(), i == n_scan - 1);
      end

      if (broken) begin
         if ($urandom_range(1)) send_stray(KIND_RENDER);
         return;
      end
      // scan beat after a completed scan
      if ($urandom_range(99) < 10) send_stray(KIND_SCAN);

      n_render = cells;
      if ($urandom_range(99) < 20) n_render = cells + $urandom_range(1, cells);
      for (i = 0; i < n_render; i++) begin
         if ($urandom_range(99) < 3) send_stray(KIND_SCAN);
         j = i % cells;
         r = $urandom;
         if ($urandom_range(99) < 85) begin
            a = scan_a[j[CELL_IDX_W-1:0]];
            b = scan_b[j[CELL_IDX_W-1:0]];
         end else begin
            // random heights; those outside the scanned range hit the clamp
            a = r[15:0];
            b = r[31:16];
         end
         send_cell(KIND_RENDER, a, b, pick_mask(), r[7]);
      end
   endtask

   // Lower valid and wait until every expected beat has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   // Writes all three registers on consecutive cycles.
   task automatic load_registers(input logic dk, input logic [SIDE_W-1:0] w,
                                 input logic [SIDE_W-1:0] h);
      dims_known_set = dk;
      exp_w_set      = w;
      exp_h_set      = h;
      csr_write_en <= 1'b1;
      csr_index    <= CSR_DIMS_KNOWN;
      csr_wdata    <= {{(CSR_DATA_W-1){1'b0}}, dk};
      @(negedge clock);
      csr_index    <= CSR_EXP_WIDTH;
      csr_wdata    <= w;
      @(negedge clock);
      csr_index    <= CSR_EXP_HEIGHT;
      csr_wdata    <= h;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic run_phase(input logic dk, input int unsigned w, input int unsigned h,
                            input int unsigned budget, input int unsigned gap_pct,
                            input int unsigned stall_pct);
      int unsigned stop_at;
      wait_drained();
      load_registers(dk, w[SIDE_W-1:0], h[SIDE_W-1:0]);
      send_gap_pct   = gap_pct;
      recv_stall_pct = stall_pct;
      stop_at = beats_sent + budget;
      while (beats_sent < stop_at) begin
         if ($urandom_range(99) < 15) send_noise();
         run_grid_session();
      end
   endtask

   initial begin : stimulus
      req_type beat;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed part, registers still at reset values ---
      // beats before any header are out of order, as is the unused kind
      send_cell(KIND_RENDER, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_cell(KIND_SCAN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      beat = random_beat();
      beat.kind = KIND_UNUSED;
      send_beat(beat);

      // bad headers: magic, version, each dimension under and over range
      send_header(HDR_MAGIC ^ 32'h1, HDR_VERSION, 2, 2);
      send_header(HDR_MAGIC, HDR_VERSION - 1, 2, 2);
      send_header(HDR_MAGIC, HDR_VERSION, 1, 2);
      send_header(HDR_MAGIC, HDR_VERSION, 2, MAX_SIDE_DEFAULT + 1);
      send_header(HDR_MAGIC, HDR_VERSION, 32'hFFFF_FFFF, 0);

      // largest legal grid, then a last cell far too early: count miss, and the
      // header is gone afterwards
      send_header(HDR_MAGIC, HDR_VERSION, MAX_SIDE_DEFAULT, MAX_SIDE_DEFAULT);
      send_cell(KIND_SCAN, 16'h0001, 16'h0002, 16'h0000, 1'b1);
      send_cell(KIND_SCAN, 16'h0001, 16'h0002, 16'h0000, 1'b0);

      // 2x2 flat grid: every sum is 100, so the span falls back to one
      send_header(HDR_MAGIC, HDR_VERSION, 2, 2);
      send_cell(KIND_SCAN, 16'd100, 16'd0, 16'h0000, 1'b0);
      send_cell(KIND_SCAN, 16'd50, 16'd50, 16'h9000, 1'b0);
      send_cell(KIND_SCAN, 16'd0, 16'd100, 16'h0000, 1'b0);
      send_cell(KIND_SCAN, 16'd60, 16'd40, 16'hFFFF, 1'b1);
      // scan after the scan completed
      send_cell(KIND_SCAN, 16'd1, 16'd1, 16'h0000, 1'b1);
      // below, far above (clamped) and at the level; tint by either bit;
      // last_cell on a render beat is ignored; fifth pixel wraps to the start
      send_cell(KIND_RENDER, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_cell(KIND_RENDER, 16'hFFFF, 16'hFFFF, 16'h8000, 1'b0);
      send_cell(KIND_RENDER, 16'd100, 16'd0, 16'h1000, 1'b1);
      send_cell(KIND_RENDER, 16'hFFFF, 16'h0001, 16'hFFFF, 1'b0);
      send_cell(KIND_RENDER, 16'd50, 16'd50, 16'h0000, 1'b0);

      // 2x2 grid spanning the whole sum range
      send_header(HDR_MAGIC, HDR_VERSION, 2, 2);
      send_cell(KIND_SCAN, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_cell(KIND_SCAN, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
      send_cell(KIND_SCAN, 16'd1234, 16'd4321, 16'h0000, 1'b0);
      send_cell(KIND_SCAN, 16'hFFFF, 16'h0000, 16'h0000, 1'b1);
      send_cell(KIND_RENDER, 16'hFFFF, 16'hFFFF, 16'h9000, 1'b0);

      // --- random part: six register settings over three pacing mixes ---
      run_phase(1'b1, 3, 5, 300, 12, 86);
      run_phase(1'b1, MAX_SIDE_DEFAULT, MAX_SIDE_DEFAULT, 60, 12, 86);
      run_phase(1'b0, 0, MAX_SIDE_DEFAULT, 300, 86, 12);
      run_phase(1'b1, 2, 2, 200, 86, 12);
      run_phase(1'b1, 0, 0, 40, 0, 0);
      run_phase(1'b0, MAX_SIDE_DEFAULT, 2, 650, 0, 0);

      // drain, then leave time for any stray extra beat to show up
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d request beats over six register settings and three pacing mixes",
               beats_sent);
      $display("Checked %0d pixels in %0d finished frames and %0d status-only results",
               pixel_count, frame_count, status_count);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
